/* hdl/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants for the parking maneuver sequencer
// Fixed-point: angles in 1/16 degree, distances in mm, speeds in mm/s.
// ----------------------------------------------------------------------------
package pms_pkg;

   // configuration register indexes
   localparam int CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CSR_REF_HEADING     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CRUISE_SPEED    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_IDLE_SPEED      = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_STANDSTILL_WAIT = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_FINISH_WAIT     = 3'd4;
   localparam int CsrDataW = 14;

   // stream payload widths
   localparam int ReqDataW = 64;  // 62 bits of fields, zero filled
   localparam int RspDataW = 24;  // 18 bits of fields, zero filled

   // thresholds
   localparam logic signed [16:0] HALF_TURN = 17'sd2880;
   localparam logic signed [16:0] FULL_TURN = 17'sd5760;
   localparam logic signed [16:0] ERR_15DEG = 17'sd240;
   localparam logic signed [16:0] ERR_80DEG = 17'sd1280;
   localparam logic signed [16:0] ERR_87DEG = 17'sd1392;
   localparam logic [11:0]        REAR_LEFT_MIN = 12'd150;
   localparam logic [11:0]        REAR_MIN      = 12'd300;
   localparam logic signed [15:0] CROSS_FIRST   = 16'sd250;
   localparam logic signed [15:0] CROSS_FINAL   = 16'sd750;

   // steering codes
   localparam logic [1:0] STEER_CENTER = 2'd0;
   localparam logic [1:0] STEER_LEFT   = 2'd1;
   localparam logic [1:0] STEER_RIGHT  = 2'd2;

   typedef enum logic [10:0] {
      PH_READY      = 11'b000_0000_0001,
      PH_BEGIN      = 11'b000_0000_0010,
      PH_WAIT_STILL = 11'b000_0000_0100,
      PH_LEFT15     = 11'b000_0000_1000,
      PH_REV_RIGHT  = 11'b000_0001_0000,
      PH_LEFT87     = 11'b000_0010_0000,
      PH_REV_A      = 11'b000_0100_0000,
      PH_REV_B      = 11'b000_1000_0000,
      PH_REV_C      = 11'b001_0000_0000,
      PH_WAIT_FIN   = 11'b010_0000_0000,
      PH_FINISH     = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic signed [13:0] ref_heading;
      logic [10:0]        cruise_speed;
      logic signed [11:0] idle_speed;
      logic [7:0]         standstill_wait;
      logic [7:0]         finish_wait;
   } cfg_type;

   typedef struct packed {
      logic               action;
      logic signed [13:0] heading;
      logic signed [13:0] cross_dist;
      logic [11:0]        rear_left_dist;
      logic [11:0]        rear_dist;
      logic [9:0]         brake_dist;
   } req_item_type;

   typedef struct packed {
      logic signed [11:0] speed_cmd;
      logic [1:0]         steer_cmd;
      logic [3:0]         phase;
      logic               done_res;
   } rsp_item_type;

   function automatic logic [3:0] phase_num(input phase_type ph);
      logic [3:0] n;
      case (ph)
         PH_READY:      n = 4'd0;
         PH_BEGIN:      n = 4'd1;
         PH_WAIT_STILL: n = 4'd2;
         PH_LEFT15:     n = 4'd3;
         PH_REV_RIGHT:  n = 4'd4;
         PH_LEFT87:     n = 4'd5;
         PH_REV_A:      n = 4'd6;
         PH_REV_B:      n = 4'd7;
         PH_REV_C:      n = 4'd8;
         PH_WAIT_FIN:   n = 4'd9;
         PH_FINISH:     n = 4'd10;
         default:       n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

/* hdl/pms_core.sv */
// ----------------------------------------------------------------------------
// pms_core: maneuver state machine
// Holds phase and wait counter; computes one result per tick item.
// ----------------------------------------------------------------------------
module pms_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pms_pkg::req_item_type item,
   input  pms_pkg::cfg_type      cfg,
   output pms_pkg::rsp_item_type result
);
   import pms_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] wait_ff, wait_in;

   logic signed [16:0] ref_x, hdg_x, diff, diff_neg, diff_abs, wrapped, err;
   logic signed [14:0] cross_x;
   logic signed [15:0] cross_abs, final_thr;
   logic [7:0]         wait_dec;
   logic signed [11:0] cruise_pos, cruise_neg;

   always_comb begin
      ref_x    = {{3{cfg.ref_heading[13]}}, cfg.ref_heading};
      hdg_x    = {{3{item.heading[13]}}, item.heading};
      diff     = ref_x - hdg_x;
      diff_neg = -diff;
      diff_abs = diff[16] ? diff_neg : diff;
      // single wrap toward zero
      if (diff_abs > HALF_TURN) begin
         wrapped = (ref_x > hdg_x) ? (diff - FULL_TURN) : (diff + FULL_TURN);
      end else begin
         wrapped = diff;
      end
      err = wrapped[16] ? -wrapped : wrapped;

      cross_x   = {item.cross_dist[13], item.cross_dist};
      cross_abs = {1'b0, (cross_x[14] ? -cross_x : cross_x)};
      final_thr = CROSS_FINAL - {6'd0, item.brake_dist};

      cruise_pos = {1'b0, cfg.cruise_speed};
      cruise_neg = -cruise_pos;
      wait_dec   = (wait_ff != 8'd0) ? wait_ff - 8'd1 : wait_ff;
   end

   always_comb begin
      phase_in         = phase_ff;
      wait_in          = wait_dec;
      result.speed_cmd = cfg.idle_speed;
      result.steer_cmd = STEER_CENTER;
      result.done_res  = 1'b0;
      case (phase_ff)
         PH_BEGIN: begin
            phase_in = PH_WAIT_STILL;
            wait_in  = cfg.standstill_wait;
         end
         PH_WAIT_STILL: begin
            if (wait_dec == 8'd0) phase_in = PH_LEFT15;
         end
         PH_LEFT15: begin
            result.steer_cmd = STEER_LEFT;
            result.speed_cmd = cruise_pos;
            if (err > ERR_15DEG) phase_in = PH_REV_RIGHT;
         end
         PH_REV_RIGHT: begin
            result.steer_cmd = STEER_RIGHT;
            result.speed_cmd = cruise_neg;
            if (err > ERR_80DEG || item.rear_left_dist < REAR_LEFT_MIN) begin
               phase_in = PH_LEFT87;
            end
         end
         PH_LEFT87: begin
            result.steer_cmd = STEER_LEFT;
            result.speed_cmd = cruise_pos;
            if (err > ERR_87DEG) phase_in = PH_REV_A;
         end
         PH_REV_A: begin
            result.speed_cmd = cruise_neg;
            if (cross_abs > CROSS_FIRST) phase_in = PH_REV_B;
         end
         PH_REV_B: begin
            result.speed_cmd = cruise_neg;
            phase_in         = PH_REV_C;
         end
         PH_REV_C: begin
            result.speed_cmd = cruise_neg;
            if (cross_abs > final_thr || item.rear_dist < REAR_MIN) begin
               phase_in = PH_WAIT_FIN;
               wait_in  = cfg.finish_wait;
            end
         end
         PH_WAIT_FIN: begin
            if (wait_dec == 8'd0) phase_in = PH_FINISH;
         end
         PH_FINISH: begin
            if (wait_dec == 8'd0) begin
               phase_in        = PH_READY;
               result.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      result.phase = phase_num(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READY;
         wait_ff  <= 8'd0;
      end else if (step) begin
         if (item.action) begin
            phase_ff <= PH_BEGIN;  // restart, counter untouched
         end else begin
            phase_ff <= phase_in;
            wait_ff  <= wait_in;
         end
      end
   end

endmodule

/* hdl/parking_maneuver_sequencer.sv */
// ----------------------------------------------------------------------------
// parking_maneuver_sequencer: reverse perpendicular parking sequencer
// Input register, state machine core, result register; streaming channels.
// ----------------------------------------------------------------------------
// A tick item's result passes the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; the single state
// update per item in the core sets it. A start item produces no result.
// Reset: phase goes to ready, wait counter to zero, registers to defaults,
// both pipeline stages empty.
module parking_maneuver_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // heading, cross_dist, rear_left_dist, rear_dist, brake_dist
   input  logic [pms_pkg::ReqDataW-1:0]    req_tdata,
   // action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // speed_cmd, steer_cmd, phase
   output logic [pms_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                            rsp_tlast,  // done_res
   input  logic                            csr_we,
   input  logic [pms_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [pms_pkg::CsrDataW-1:0]    csr_wdata
);
   import pms_pkg::*;

   cfg_type      cfg_ff;
   req_item_type item_ff;
   logic         item_vld_ff;
   rsp_item_type rsp_ff;
   logic         rsp_vld_ff;
   rsp_item_type result;
   logic         out_free, step;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   // start items retire without touching the result register
   assign step       = item_vld_ff && (item_ff.action || out_free);
   assign req_tready = !item_vld_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_heading     <= 14'sd0;
         cfg_ff.cruise_speed    <= 11'd350;
         cfg_ff.idle_speed      <= 12'sd0;
         cfg_ff.standstill_wait <= 8'd5;
         cfg_ff.finish_wait     <= 8'd40;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REF_HEADING:     cfg_ff.ref_heading     <= csr_wdata;
            CSR_CRUISE_SPEED:    cfg_ff.cruise_speed    <= csr_wdata[10:0];
            CSR_IDLE_SPEED:      cfg_ff.idle_speed      <= csr_wdata[11:0];
            CSR_STANDSTILL_WAIT: cfg_ff.standstill_wait <= csr_wdata[7:0];
            CSR_FINISH_WAIT:     cfg_ff.finish_wait     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_tready) begin
         item_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         item_ff.action         <= req_tuser;
         item_ff.heading        <= req_tdata[13:0];
         item_ff.cross_dist     <= req_tdata[27:14];
         item_ff.rear_left_dist <= req_tdata[39:28];
         item_ff.rear_dist      <= req_tdata[51:40];
         item_ff.brake_dist     <= req_tdata[61:52];
      end
   end

   pms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= step && !item_ff.action;
      end
      if (out_free && step && !item_ff.action) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.phase, rsp_ff.steer_cmd, rsp_ff.speed_cmd};
   assign rsp_tlast  = rsp_ff.done_res;

endmodule
